[design/mcfr_pkg.sv]
// ============================================================================
// mcfr_pkg
// Shared types, framing bytes, result kinds and decode helpers for the
// six-channel frame receiver.
// ============================================================================
`default_nettype none

package mcfr_pkg;

    localparam int NCHAN = 6;
    localparam int CHW   = 3;

    localparam logic [CHW-1:0] CH_CELL  = 3'd0;
    localparam logic [CHW-1:0] CH_BASIC = 3'd1;
    localparam logic [CHW-1:0] CH_CAL   = 3'd2;
    localparam logic [CHW-1:0] CH_WRITE = 3'd3;
    localparam logic [CHW-1:0] CH_READ  = 3'd4;
    localparam logic [CHW-1:0] CH_LOG   = 3'd5;

    // start-of-frame byte per channel, in channel order
    localparam logic [7:0] START_BYTE [NCHAN] = '{8'hAA, 8'hBB, 8'hCC, 8'hFD, 8'hFE, 8'hDD};

    localparam logic [7:0] END_CELL   = 8'h55;
    localparam logic [7:0] END_BASIC  = 8'h66;
    localparam logic [7:0] END_STATIC = 8'h77;
    localparam logic [7:0] END_CHARGE = 8'h78;
    localparam logic [7:0] END_DISCH  = 8'h79;
    localparam logic [7:0] END_SAMPLE = 8'h80;
    localparam logic [7:0] END_TEMP   = 8'h81;
    localparam logic [7:0] END_CLOCK  = 8'h82;
    localparam logic [7:0] END_WRITE  = 8'h99;
    localparam logic [7:0] END_READ   = 8'h98;
    localparam logic [7:0] END_LOG    = 8'h88;

    typedef enum logic [3:0] {
        KIND_CELL        = 4'd0,
        KIND_BASIC       = 4'd1,
        KIND_STATIC_CAL  = 4'd2,
        KIND_CHARGE_CAL  = 4'd3,
        KIND_DISCH_CAL   = 4'd4,
        KIND_CELL_SAMPLE = 4'd5,
        KIND_TEMP        = 4'd6,
        KIND_CLOCK       = 4'd7,
        KIND_WRITE       = 4'd8,
        KIND_READ_FRAME  = 4'd9,
        KIND_LOG         = 4'd10,
        KIND_READ_DATA   = 4'd11
    } t_kind;

    // frame positions shadowed in flops for the calibration channel
    localparam int CAL_SLOTS = 9;
    localparam int CAL_POS [CAL_SLOTS] = '{3, 4, 5, 6, 7, 8, 10, 12, 14};
    localparam int SLOT_B3  = 0;
    localparam int SLOT_B4  = 1;
    localparam int SLOT_B5  = 2;
    localparam int SLOT_B6  = 3;
    localparam int SLOT_B7  = 4;
    localparam int SLOT_B8  = 5;
    localparam int SLOT_B10 = 6;
    localparam int SLOT_B12 = 7;
    localparam int SLOT_B14 = 8;

    // and for the log channel
    localparam int LOG_SLOTS = 2;
    localparam int LOG_POS [LOG_SLOTS] = '{4, 5};
    localparam int LSLOT_B4 = 0;
    localparam int LSLOT_B5 = 1;

    typedef struct packed {
        logic           hit;
        logic [CHW-1:0] channel;
        t_kind          kind;
    } t_end_match;

    typedef struct packed {
        t_kind       kind;
        logic [8:0]  length;
        logic [15:0] value_first;
        logic [15:0] value_second;
        logic [7:0]  seconds;
        logic [7:0]  minutes;
        logic [7:0]  hours;
        logic [7:0]  date;
        logic [7:0]  weekday;
        logic [7:0]  month;
        logic [7:0]  year;
    } t_result;

    // which bank's read data belongs to a result, and whether it counts
    typedef struct packed {
        logic           hit;
        logic [CHW-1:0] channel;
    } t_read_tag;

    // End bytes are unique across channels, so one lookup covers all six.
    function automatic t_end_match match_end(input logic [7:0] b);
        t_end_match m;
        m.hit     = 1'b1;
        m.channel = CH_CELL;
        m.kind    = KIND_CELL;
        case (b)
            END_CELL: begin
                m.channel = CH_CELL;  m.kind = KIND_CELL;
            end
            END_BASIC: begin
                m.channel = CH_BASIC; m.kind = KIND_BASIC;
            end
            END_STATIC: begin
                m.channel = CH_CAL;   m.kind = KIND_STATIC_CAL;
            end
            END_CHARGE: begin
                m.channel = CH_CAL;   m.kind = KIND_CHARGE_CAL;
            end
            END_DISCH: begin
                m.channel = CH_CAL;   m.kind = KIND_DISCH_CAL;
            end
            END_SAMPLE: begin
                m.channel = CH_CAL;   m.kind = KIND_CELL_SAMPLE;
            end
            END_TEMP: begin
                m.channel = CH_CAL;   m.kind = KIND_TEMP;
            end
            END_CLOCK: begin
                m.channel = CH_CAL;   m.kind = KIND_CLOCK;
            end
            END_WRITE: begin
                m.channel = CH_WRITE; m.kind = KIND_WRITE;
            end
            END_READ: begin
                m.channel = CH_READ;  m.kind = KIND_READ_FRAME;
            end
            END_LOG: begin
                m.channel = CH_LOG;   m.kind = KIND_LOG;
            end
            default: begin
                m.hit = 1'b0;
            end
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

[design/mcfr_ram.sv]
// ============================================================================
// mcfr_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ============================================================================
`default_nettype none

module mcfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

[design/mcfr_framer.sv]
// ============================================================================
// mcfr_framer
// Per-channel open flags and fill counts, store write control, header
// shadow bytes and result decode.
// ============================================================================
`default_nettype none

module mcfr_framer
    import mcfr_pkg::*;
#(
    parameter int FRAME_MAX = 256,
    localparam int CNTW     = $clog2(FRAME_MAX + 1),
    localparam int AW       = $clog2(FRAME_MAX)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_accept,
    input  wire logic             i_command,
    input  wire logic [7:0]       i_rx_byte,
    input  wire logic [CHW-1:0]   i_channel,
    input  wire logic [7:0]       i_byte_index,
    output logic      [NCHAN-1:0] o_wr_en,
    output logic      [AW-1:0]    o_wr_addr [NCHAN],
    output logic      [NCHAN-1:0] o_rd_en,
    output logic      [AW-1:0]    o_rd_addr,
    output logic                  o_res_valid,
    output t_result               o_res,
    output t_read_tag             o_rd_tag
);

    logic [NCHAN-1:0] r_open;
    logic [CNTW-1:0]  r_count [NCHAN];
    logic [7:0]       r_cal [CAL_SLOTS];
    logic [7:0]       r_log [LOG_SLOTS];

    logic [NCHAN-1:0] start;
    logic [NCHAN-1:0] open_cur;
    logic [NCHAN-1:0] n_open;
    logic [CNTW-1:0]  base [NCHAN];
    logic [CNTW-1:0]  n_count [NCHAN];
    logic [7:0]       n_cal [CAL_SLOTS];
    logic [7:0]       n_log [LOG_SLOTS];
    logic [7:0]       cal_b [CAL_SLOTS];
    logic [7:0]       log_b [LOG_SLOTS];
    logic             rx_mode;
    logic             end_fire;
    logic             ch_ok;
    logic [AW+7:0]    idx_wide;
    logic [CNTW+7:0]  idx_cmp;
    logic [CNTW+7:0]  cnt_cmp;
    t_end_match       em;

    function automatic logic [8:0] to_len(input logic [CNTW-1:0] c);
        logic [CNTW+8:0] w;
        w = {9'd0, c};
        return w[8:0];
    endfunction

    assign rx_mode = i_accept && !i_command;
    assign em      = match_end(i_rx_byte);

    always_comb begin
        for (int ch = 0; ch < NCHAN; ch++) begin
            start[ch]    = (i_rx_byte == START_BYTE[ch]);
            open_cur[ch] = start[ch] || r_open[ch];
            base[ch]     = start[ch] ? '0 : r_count[ch];
            o_wr_en[ch]  = rx_mode && open_cur[ch] && (base[ch] < CNTW'(FRAME_MAX));
            o_wr_addr[ch] = base[ch][AW-1:0];
            n_count[ch]  = base[ch] + CNTW'(o_wr_en[ch]);
        end
    end

    // a start byte never doubles as an end byte, so open_cur is the old flag here
    assign end_fire = rx_mode && em.hit && open_cur[em.channel];

    always_comb begin
        for (int ch = 0; ch < NCHAN; ch++) begin
            n_open[ch] = open_cur[ch] && !(end_fire && (em.channel == CHW'(ch)));
        end
    end

    // header shadows with forwarding of the byte written this cycle
    always_comb begin
        for (int j = 0; j < CAL_SLOTS; j++) begin
            n_cal[j] = (o_wr_en[CH_CAL] && (base[CH_CAL] == CNTW'(CAL_POS[j])))
                       ? i_rx_byte : r_cal[j];
            cal_b[j] = (CNTW'(CAL_POS[j]) < n_count[CH_CAL]) ? n_cal[j] : 8'd0;
        end
        for (int j = 0; j < LOG_SLOTS; j++) begin
            n_log[j] = (o_wr_en[CH_LOG] && (base[CH_LOG] == CNTW'(LOG_POS[j])))
                       ? i_rx_byte : r_log[j];
            log_b[j] = (CNTW'(LOG_POS[j]) < n_count[CH_LOG]) ? n_log[j] : 8'd0;
        end
    end

    assign ch_ok     = (i_channel < CHW'(NCHAN));
    assign idx_wide  = {AW'(0), i_byte_index};
    assign o_rd_addr = idx_wide[AW-1:0];
    assign idx_cmp   = {CNTW'(0), i_byte_index};

    always_comb begin
        for (int ch = 0; ch < NCHAN; ch++) begin
            o_rd_en[ch] = i_accept && i_command && (i_channel == CHW'(ch));
        end
    end

    always_comb begin
        o_res       = '0;
        o_rd_tag    = '0;
        cnt_cmp     = '0;
        o_res_valid = (i_accept && i_command) || end_fire;
        if (i_command) begin
            o_res.kind       = KIND_READ_DATA;
            o_rd_tag.channel = i_channel;
            if (ch_ok) begin
                cnt_cmp      = {8'd0, r_count[i_channel]};
                o_res.length = to_len(r_count[i_channel]);
                o_rd_tag.hit = (idx_cmp < cnt_cmp);
            end
        end else begin
            o_res.kind   = em.kind;
            o_res.length = to_len(n_count[em.channel]);
            case (em.kind)
                KIND_CHARGE_CAL, KIND_DISCH_CAL: begin
                    o_res.value_first = {cal_b[SLOT_B5], cal_b[SLOT_B4]};
                end
                KIND_CELL_SAMPLE, KIND_TEMP: begin
                    o_res.value_first  = {8'd0, cal_b[SLOT_B4]};
                    o_res.value_second = {cal_b[SLOT_B7], cal_b[SLOT_B6]};
                end
                KIND_CLOCK: begin
                    o_res.seconds = cal_b[SLOT_B3];
                    o_res.minutes = cal_b[SLOT_B4];
                    o_res.hours   = cal_b[SLOT_B6];
                    o_res.date    = cal_b[SLOT_B8];
                    o_res.weekday = cal_b[SLOT_B10];
                    o_res.month   = cal_b[SLOT_B12];
                    o_res.year    = cal_b[SLOT_B14];
                end
                KIND_LOG: begin
                    // count doubled, 16-bit wrap
                    o_res.value_first = {log_b[LSLOT_B5][6:0], log_b[LSLOT_B4], 1'b0};
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= '0;
            for (int ch = 0; ch < NCHAN; ch++) begin
                r_count[ch] <= '0;
            end
        end else if (rx_mode) begin
            r_open <= n_open;
            for (int ch = 0; ch < NCHAN; ch++) begin
                r_count[ch] <= n_count[ch];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < CAL_SLOTS; j++) begin
            r_cal[j] <= n_cal[j];
        end
        for (int j = 0; j < LOG_SLOTS; j++) begin
            r_log[j] <= n_log[j];
        end
    end

endmodule

`default_nettype wire

[design/multi_channel_frame_receiver_unit.sv]
// ============================================================================
// multi_channel_frame_receiver_unit
// Six-channel serial frame receiver: stores framed bytes per channel,
// decodes finished frames and serves byte reads from the frame store.
// ============================================================================
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+---------------------------
//  in      | to block  | i_in_valid / o_in_stall   | command, rx_byte, channel,
//          |           |                           | byte_index
//  out     | from block| o_out_valid / i_out_stall | kind, frame_length, values,
//          |           |                           | read_byte, clock fields
//
//  One input transaction per cycle while the output side keeps up. A result
//  is registered in stage 1 together with the registered read of the frame
//  store bank, and then in the output register. Reset clears every
//  channel's open flag and fill count; the frame store itself is not
//  cleared, and bytes at or past a channel's count read as zero. A stalled
//  output holds the result; the stage behind it still takes one transaction
//  before o_in_stall rises.
//
`default_nettype none

module multi_channel_frame_receiver_unit
    import mcfr_pkg::*;
#(
    parameter int FRAME_MAX = 256
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    // input transactions
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    input  wire logic           i_command,
    input  wire logic [7:0]     i_rx_byte,
    input  wire logic [CHW-1:0] i_channel,
    input  wire logic [7:0]     i_byte_index,
    // result transactions
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output logic      [3:0]     o_kind,
    output logic      [8:0]     o_frame_length,
    output logic      [15:0]    o_value_first,
    output logic      [15:0]    o_value_second,
    output logic      [7:0]     o_read_byte,
    output logic      [7:0]     o_clock_seconds,
    output logic      [7:0]     o_clock_minutes,
    output logic      [7:0]     o_clock_hours,
    output logic      [7:0]     o_clock_date,
    output logic      [7:0]     o_clock_weekday,
    output logic      [7:0]     o_clock_month,
    output logic      [7:0]     o_clock_year
);

    localparam int AW = $clog2(FRAME_MAX);

    logic             accept;
    logic             s1_move;
    logic [NCHAN-1:0] wr_en;
    logic [AW-1:0]    wr_addr [NCHAN];
    logic [NCHAN-1:0] rd_en;
    logic [AW-1:0]    rd_addr;
    logic [7:0]       rd_data [NCHAN];
    logic             res_valid;
    t_result          res;
    t_read_tag        rd_tag;

    // stage 1: decoded result waiting on the bank read
    logic             r_s1_valid;
    t_result          r_s1_res;
    t_read_tag        r_s1_tag;

    // stage 2: output register
    logic             r_out_valid;
    t_result          r_out_res;
    logic [7:0]       r_out_byte;

    // Stage 1 drains whenever the output register is empty or being taken.
    assign s1_move    = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    mcfr_framer #(
        .FRAME_MAX (FRAME_MAX)
    ) u_framer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_command    (i_command),
        .i_rx_byte    (i_rx_byte),
        .i_channel    (i_channel),
        .i_byte_index (i_byte_index),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_rd_en      (rd_en),
        .o_rd_addr    (rd_addr),
        .o_res_valid  (res_valid),
        .o_res        (res),
        .o_rd_tag     (rd_tag)
    );

    // One bank per channel: every open channel with room left stores the same
    // byte at its own fill position in the same cycle.
    for (genvar g = 0; g < NCHAN; g++) begin : g_bank
        mcfr_ram #(
            .WIDTH (8),
            .DEPTH (FRAME_MAX)
        ) u_bank (
            .i_clk     (i_clk),
            .i_wr_en   (wr_en[g]),
            .i_wr_addr (wr_addr[g]),
            .i_wr_data (i_rx_byte),
            .i_rd_en   (rd_en[g]),
            .i_rd_addr (rd_addr),
            .o_rd_data (rd_data[g])
        );
    end

    // Bank read data holds until the next read, and no read is issued while
    // stage 1 is stuck, so the byte is still there when stage 1 drains.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (res_valid) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_s1_res <= res;
            r_s1_tag <= rd_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_res  <= r_s1_res;
            r_out_byte <= r_s1_tag.hit ? rd_data[r_s1_tag.channel] : 8'd0;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_kind          = r_out_res.kind;
    assign o_frame_length  = r_out_res.length;
    assign o_value_first   = r_out_res.value_first;
    assign o_value_second  = r_out_res.value_second;
    assign o_read_byte     = r_out_byte;
    assign o_clock_seconds = r_out_res.seconds;
    assign o_clock_minutes = r_out_res.minutes;
    assign o_clock_hours   = r_out_res.hours;
    assign o_clock_date    = r_out_res.date;
    assign o_clock_weekday = r_out_res.weekday;
    assign o_clock_month   = r_out_res.month;
    assign o_clock_year    = r_out_res.year;

endmodule

`default_nettype wire

[design/mcfr_checker.sv]
// ============================================================================
// mcfr_checker
// Port-level checks for the frame receiver, bound to the top level.
// ============================================================================
`default_nettype none

module mcfr_checker
    import mcfr_pkg::*;
(
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           i_in_valid,
    input wire logic           o_in_stall,
    input wire logic           i_command,
    input wire logic [CHW-1:0] i_channel,
    input wire logic           o_out_valid,
    input wire logic           i_out_stall,
    input wire logic [3:0]     o_kind,
    input wire logic [8:0]     o_frame_length,
    input wire logic [15:0]    o_value_first,
    input wire logic [7:0]     o_read_byte
);

    logic in_acc;
    assign in_acc = i_in_valid && !o_in_stall;

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_kind)
            && $stable(o_frame_length) && $stable(o_value_first) && $stable(o_read_byte))
        else $error("stalled result changed");

    // input back-pressure only comes from a blocked output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled while output free");

    // a read transaction reaches the output once the output register frees
    a_read_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_command) ##1 !(o_out_valid && i_out_stall)
            |=> o_out_valid && (o_kind == KIND_READ_DATA))
        else $error("read result missing");

    // reads of a channel number past the last channel return zeros
    a_read_bad_channel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_command && (i_channel == 3'd6 || i_channel == 3'd7))
            ##1 !(o_out_valid && i_out_stall)
            |=> o_read_byte == 8'd0 && o_frame_length == 9'd0)
        else $error("bad channel read not zero");

endmodule

bind multi_channel_frame_receiver_unit mcfr_checker u_mcfr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .i_command      (i_command),
    .i_channel      (i_channel),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_kind         (o_kind),
    .o_frame_length (o_frame_length),
    .o_value_first  (o_value_first),
    .o_read_byte    (o_read_byte)
);

`default_nettype wire
